[design/source_text_tokenizer_top_assert.svh]
// assertion macros used by the tokenizer port checks
`ifndef SOURCE_TEXT_TOKENIZER_TOP_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_TOP_ASSERT_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define STT_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define STT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

[design/stt_pkg.sv]
// types, constants and character classes of the source text tokenizer
package stt_pkg;

  localparam int unsigned PosBits     = 32;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned PtrBits     = $clog2(QueueDepth);
  localparam int unsigned CntBits     = $clog2(QueueDepth + 1);
  localparam int unsigned KwNum       = 6;
  localparam int unsigned KwMaxLen    = 11;
  localparam int unsigned WordCntBits = 4;

  typedef logic [PosBits-1:0] pos_t;

  typedef enum logic [2:0] {
    ModeIdle,
    ModeWord,
    ModeInclude,
    ModeString,
    ModeColon,
    ModeMinus
  } mode_e;

  typedef enum logic [2:0] {
    KindEnd     = 3'd0,
    KindInclude = 3'd1,
    KindSymbol  = 3'd2,
    KindKeyword = 3'd3,
    KindIdent   = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    KwNone        = 3'd0,
    KwClass       = 3'd1,
    KwFn          = 3'd2,
    KwConstructor = 3'd3,
    KwEnum        = 3'd4,
    KwInterface   = 3'd5
  } kw_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [2:0]  keyword_code;
    logic        is_quoted;
    logic [31:0] token_start;
    logic [31:0] token_length;
    logic        last_of_run;
  } out_item_t;

  // results of one input item, written into the queue together
  typedef struct packed {
    logic [1:0] num;
    out_item_t  first;
    out_item_t  second;
  } push_t;

  // keyword spellings, right-aligned
  localparam logic [8*KwMaxLen-1:0] KwText [KwNum] = '{
    "class", "fn", "function", "constructor", "enum", "interface"
  };
  localparam int unsigned KwLen [KwNum] = '{5, 2, 8, 11, 4, 9};
  localparam kw_e KwCode [KwNum] = '{
    KwClass, KwFn, KwFn, KwConstructor, KwEnum, KwInterface
  };

  function automatic logic is_space(input logic [7:0] b);
    return b inside {8'h20, [8'h09:8'h0d]};
  endfunction

  function automatic logic is_alnum(input logic [7:0] b);
    return b inside {["0":"9"], ["a":"z"], ["A":"Z"]};
  endfunction

  function automatic logic is_word_mark(input logic [7:0] b);
    return b inside {"_", "@", "&", "[", "]", "!", "|", ".", "#", "?"};
  endfunction

  function automatic logic is_punct(input logic [7:0] b);
    return b inside {"{", "}", "(", ")", ";", ".", ",", ":",
                     "<", ">", "+", "-", "*", "/", "=", "%"};
  endfunction

  // character of keyword k at position idx, zero past its end
  function automatic logic [7:0] kw_char(input int unsigned k,
                                         input logic [WordCntBits-1:0] idx);
    logic [7:0] c;
    c = 8'h00;
    for (int unsigned i = 0; i < KwMaxLen; i++) begin
      if (i < KwLen[k] && idx == WordCntBits'(i)) begin
        c = KwText[k][8*(KwLen[k]-1-i) +: 8];
      end
    end
    return c;
  endfunction

  // drop keyword candidates that byte b at position idx rules out
  function automatic logic [KwNum-1:0] cand_update(input logic [KwNum-1:0] cands,
                                                   input logic [WordCntBits-1:0] idx,
                                                   input logic [7:0] b);
    logic [KwNum-1:0] res;
    res = cands;
    for (int unsigned k = 0; k < KwNum; k++) begin
      if (idx >= WordCntBits'(KwLen[k]) || kw_char(k, idx) != b) begin
        res[k] = 1'b0;
      end
    end
    return res;
  endfunction

endpackage

[design/stt_front.sv]
// scanner front end: takes bytes, tracks the open token, produces results
module stt_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  stt_pkg::in_item_t in_item_i,
  input  logic             room_i,
  output stt_pkg::push_t   push_o
);
  import stt_pkg::*;

  mode_e            mode_q, mode_d;
  pos_t             origin_q, origin_d;
  pos_t             pos_q, pos_d;
  logic             single_q, single_d;
  logic             bs_q, bs_d;
  logic [KwNum-1:0] cand_q, cand_d;
  logic [WordCntBits-1:0] wcnt_q, wcnt_d;

  logic       accept;
  logic [7:0] b;
  logic       eot;
  logic       word_inc, col_min, cont, close, pair;
  logic       do_first, do_restart, start_sym, second_valid;
  logic [7:0] quote_ch;
  pos_t       flush_len;
  kw_e        kw_code;
  out_item_t  first_tok, second_tok;

  assign in_ready_o = room_i;
  assign accept     = in_valid_i && room_i;
  assign b          = in_item_i.text_byte;
  assign eot        = in_item_i.end_of_text;

  // byte decode against the current mode
  assign word_inc  = (mode_q == ModeWord) || (mode_q == ModeInclude);
  assign col_min   = (mode_q == ModeColon) || (mode_q == ModeMinus);
  assign cont      = is_alnum(b) || is_word_mark(b);
  assign quote_ch  = single_q ? 8'h27 : 8'h22;
  assign close     = !eot && (mode_q == ModeString) && (b == quote_ch) && !bs_q;
  assign pair      = !eot && (((mode_q == ModeColon) && (b == ":")) ||
                              ((mode_q == ModeMinus) && (b == ">")));
  assign do_first  = eot ? (mode_q != ModeIdle)
                         : ((word_inc && !cont) || close || col_min);
  assign do_restart = !eot && ((mode_q == ModeIdle) || (word_inc && !cont) ||
                               (col_min && !pair));
  assign start_sym = !(b == "@" || b == ":" || b == "-") &&
                     (is_punct(b) || (is_word_mark(b) && b != "_"));
  assign second_valid = eot || (do_restart && start_sym);
  assign flush_len = pos_q - origin_q + pos_t'(close);

  always_comb begin
    kw_code = KwNone;
    for (int unsigned k = 0; k < KwNum; k++) begin
      if (cand_q[k] && wcnt_q == WordCntBits'(KwLen[k])) begin
        kw_code = KwCode[k];
      end
    end
  end

  // next state
  always_comb begin
    mode_d   = mode_q;
    origin_d = origin_q;
    pos_d    = pos_q;
    single_d = single_q;
    bs_d     = bs_q;
    cand_d   = cand_q;
    wcnt_d   = wcnt_q;
    if (accept) begin
      if (eot) begin
        mode_d   = ModeIdle;
        origin_d = '0;
        pos_d    = '0;
        single_d = 1'b0;
        bs_d     = 1'b0;
        cand_d   = '1;
        wcnt_d   = '0;
      end else begin
        pos_d = pos_q + pos_t'(1);
        case (mode_q)
          ModeString: begin
            bs_d = (b == "\\");
            if (close) begin
              mode_d = ModeIdle;
            end
          end
          ModeWord: begin
            if (cont) begin
              cand_d = cand_update(cand_q, wcnt_q, b);
              if (wcnt_q != '1) begin
                wcnt_d = wcnt_q + WordCntBits'(1);
              end
            end
          end
          ModeColon, ModeMinus: begin
            if (pair) begin
              mode_d = ModeIdle;
            end
          end
          default: ;
        endcase
        if (do_restart) begin
          mode_d = ModeIdle;
          if (!is_space(b)) begin
            origin_d = pos_q;
          end
          if (b == "@") begin
            mode_d = ModeInclude;
          end else if (b == ":") begin
            mode_d = ModeColon;
          end else if (b == "-") begin
            mode_d = ModeMinus;
          end else if (start_sym) begin
            mode_d = ModeIdle;
          end else if (is_alnum(b) || b == "_") begin
            mode_d = ModeWord;
            cand_d = cand_update('1, '0, b);
            wcnt_d = WordCntBits'(1);
          end else if (b == 8'h22 || b == 8'h27) begin
            mode_d   = ModeString;
            single_d = (b == 8'h27);
            bs_d     = 1'b0;
          end
        end
      end
    end
  end

  // results
  always_comb begin
    first_tok              = '0;
    first_tok.token_start  = 32'(origin_q);
    first_tok.token_length = 32'(flush_len);
    case (mode_q)
      ModeWord: begin
        if (kw_code != KwNone) begin
          first_tok.token_kind   = KindKeyword;
          first_tok.keyword_code = kw_code;
        end else begin
          first_tok.token_kind = KindIdent;
        end
      end
      ModeInclude: first_tok.token_kind = KindInclude;
      ModeString: begin
        first_tok.token_kind = KindIdent;
        first_tok.is_quoted  = 1'b1;
      end
      ModeColon, ModeMinus: begin
        first_tok.token_kind   = KindSymbol;
        first_tok.token_length = pair ? 32'd2 : 32'd1;
      end
      default: ;
    endcase

    second_tok             = '0;
    second_tok.token_start = 32'(pos_q);
    if (eot) begin
      second_tok.token_kind = KindEnd;
    end else begin
      second_tok.token_kind   = KindSymbol;
      second_tok.token_length = 32'd1;
    end

    push_o = '0;
    if (accept) begin
      if (do_first && second_valid) begin
        push_o.num                = 2'd2;
        push_o.first              = first_tok;
        push_o.second             = second_tok;
        push_o.second.last_of_run = 1'b1;
      end else if (do_first) begin
        push_o.num               = 2'd1;
        push_o.first             = first_tok;
        push_o.first.last_of_run = 1'b1;
      end else if (second_valid) begin
        push_o.num               = 2'd1;
        push_o.first             = second_tok;
        push_o.first.last_of_run = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeIdle;
      origin_q <= '0;
      pos_q    <= '0;
      single_q <= 1'b0;
      bs_q     <= 1'b0;
      cand_q   <= '1;
      wcnt_q   <= '0;
    end else begin
      mode_q   <= mode_d;
      origin_q <= origin_d;
      pos_q    <= pos_d;
      single_q <= single_d;
      bs_q     <= bs_d;
      cand_q   <= cand_d;
      wcnt_q   <= wcnt_d;
    end
  end

endmodule

[design/stt_queue.sv]
// result queue between scanner and output stage, two writes and one read per cycle
module stt_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stt_pkg::push_t     push_i,
  output logic               room_o,
  output logic               head_valid_o,
  output stt_pkg::out_item_t head_o,
  input  logic               pop_i
);
  import stt_pkg::*;

  out_item_t          mem_q [QueueDepth];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic [PtrBits-1:0] wr_next;

  // room for the worst case of two results
  assign room_o       = cnt_q <= CntBits'(QueueDepth - 2);
  assign head_valid_o = cnt_q != '0;
  assign head_o       = mem_q[rd_ptr_q];
  assign wr_next      = wr_ptr_q + PtrBits'(1);

  assign wr_ptr_d = wr_ptr_q + PtrBits'(push_i.num);
  assign rd_ptr_d = rd_ptr_q + PtrBits'(pop_i);
  assign cnt_d    = cnt_q + CntBits'(push_i.num) - CntBits'(pop_i);

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

[design/stt_back.sv]
// output register stage, drains the queue one result per cycle while the receiver is ready
module stt_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  stt_pkg::out_item_t head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output stt_pkg::out_item_t out_item_o
);
  import stt_pkg::*;

  logic      valid_q, valid_d;
  out_item_t item_q;

  assign pop_o       = head_valid_i && (!valid_q || out_ready_i);
  assign valid_d     = pop_o || (valid_q && !out_ready_i);
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

endmodule

[design/source_text_tokenizer_top.sv]
// top level of the source text tokenizer: scanner, result queue, output stage
// Takes source text one byte per item and returns token descriptors (kind,
// keyword code, quoted flag, start offset, length, last-of-run flag). A byte
// item is taken every clock as long as the result queue has room for two
// results; each item gives zero, one or two results, and the output stage
// hands out one result per clock while the receiver is ready, so the
// sustained rate is one byte per clock while tokens average no more than
// one per byte, and drops toward the two-per-byte pattern of the output
// port otherwise. A result is written into the queue when its byte is
// taken and reaches the output through the output register. An end-of-text
// item flushes the open token, returns an end token at the offset just past
// the text, and puts the scanner back to its reset state.
// No configuration and no clearing pass after reset.
module source_text_tokenizer_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  // byte items
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  stt_pkg::in_item_t  in_item_i,
  // token items
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output stt_pkg::out_item_t out_item_o
);
  import stt_pkg::*;

  push_t     push;
  logic      room;
  logic      head_valid;
  out_item_t head;
  logic      pop;

  // scanner: classifies each byte and closes or opens tokens
  stt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .room_i     (room),
    .push_o     (push)
  );

  // short queue decouples scanner stalls from output stalls
  stt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .room_o       (room),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  // registered output, one result per clock while the receiver is ready
  stt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule

[design/stt_checker.sv]
// port-level checks of the tokenizer and their binding to the top level
`include "source_text_tokenizer_top_assert.svh"

module stt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input stt_pkg::out_item_t out_item_i
);
  import stt_pkg::*;

  // a stalled item holds
  `STT_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_item_i))

  // end token closes its run and has no length
  `STT_ASSERT_IMP(a_end_shape, out_valid_i && out_item_i.token_kind == KindEnd, out_item_i.last_of_run && out_item_i.token_length == 32'd0)

  // keyword code only on keywords
  `STT_ASSERT_IMP(a_kw_code, out_valid_i, (out_item_i.token_kind == KindKeyword) == (out_item_i.keyword_code != 3'd0))

  // quoted only on identifiers
  `STT_ASSERT_IMP(a_quoted, out_valid_i && out_item_i.is_quoted, out_item_i.token_kind == KindIdent)

  // symbols are one or two bytes
  `STT_ASSERT_IMP(a_sym_len, out_valid_i && out_item_i.token_kind == KindSymbol, out_item_i.token_length == 32'd1 || out_item_i.token_length == 32'd2)

endmodule

bind source_text_tokenizer_top stt_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_i  (out_item_o)
);

[verif/tokenizer_checker.sv]
// token checker: watches both channels, predicts token items and compares them
`timescale 1ns / 1ps

module tokenizer_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  stt_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  stt_pkg::out_item_t out_item_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import stt_pkg::*;

  localparam int ReportMax = 10;

  // scanner copy
  mode_e      mode;
  pos_t       origin;
  pos_t       position;
  logic       quote_single;
  logic       prior_bs;
  logic [5:0] cands;

  out_item_t token_q[$];
  out_item_t run_tok[2];
  int        run_n;
  int        fails;

  function automatic string kw_spell(input int k);
    case (k)
      0: return "class";
      1: return "fn";
      2: return "function";
      3: return "constructor";
      4: return "enum";
      default: return "interface";
    endcase
  endfunction

  function automatic kw_e kw_of(input int k);
    case (k)
      0: return KwClass;
      1, 2: return KwFn;
      3: return KwConstructor;
      4: return KwEnum;
      default: return KwInterface;
    endcase
  endfunction

  function automatic logic blank(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0d);
  endfunction

  function automatic logic alnum(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic word_tail(input logic [7:0] b);
    case (b)
      "_", "@", "&", "[", "]", "!", "|", ".", "#", "?": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic symbol_char(input logic [7:0] b);
    case (b)
      "{", "}", "(", ")", ";", ".", ",", ":", "<", ">", "+", "-", "*", "/", "=", "%":
        return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic reset_scan();
    mode         = ModeIdle;
    origin       = '0;
    position     = '0;
    quote_single = 1'b0;
    prior_bs     = 1'b0;
    cands        = 6'h3f;
  endtask

  task automatic add_token(input kind_e kind, input kw_e kw, input logic quoted,
                           input pos_t start, input pos_t len);
    out_item_t t;
    t.token_kind   = kind;
    t.keyword_code = kw;
    t.is_quoted    = quoted;
    t.token_start  = start;
    t.token_length = len;
    t.last_of_run  = 1'b0;
    run_tok[run_n] = t;
    run_n++;
  endtask

  task automatic narrow_cands(input pos_t idx, input logic [7:0] b);
    string s;
    for (int k = 0; k < 6; k++) begin
      s = kw_spell(k);
      if (cands[k] && (idx >= pos_t'(s.len()) || s[int'(idx)] != b)) cands[k] = 1'b0;
    end
  endtask

  // close the open token that ends just before end_pos
  task automatic close_token(input pos_t end_pos);
    pos_t len;
    kw_e  code;
    len  = end_pos - origin;
    code = KwNone;
    case (mode)
      ModeWord: begin
        for (int k = 0; k < 6; k++) begin
          if (cands[k] && len == pos_t'(kw_spell(k).len())) code = kw_of(k);
        end
        if (code != KwNone) add_token(KindKeyword, code, 1'b0, origin, len);
        else add_token(KindIdent, KwNone, 1'b0, origin, len);
      end
      ModeInclude: add_token(KindInclude, KwNone, 1'b0, origin, len);
      ModeString:  add_token(KindIdent, KwNone, 1'b1, origin, len);
      ModeColon, ModeMinus: add_token(KindSymbol, KwNone, 1'b0, origin, 1);
      default: ;
    endcase
    mode = ModeIdle;
  endtask

  task automatic open_token(input logic [7:0] b, input pos_t p);
    mode = ModeIdle;
    if (!blank(b)) begin
      origin = p;
      if (b == "@") begin
        mode = ModeInclude;
      end else if (b == ":") begin
        mode = ModeColon;
      end else if (b == "-") begin
        mode = ModeMinus;
      end else if (symbol_char(b) || (word_tail(b) && b != "_")) begin
        add_token(KindSymbol, KwNone, 1'b0, p, 1);
      end else if (alnum(b) || b == "_") begin
        mode  = ModeWord;
        cands = 6'h3f;
        narrow_cands('0, b);
      end else if (b == "\"" || b == "'") begin
        mode         = ModeString;
        quote_single = (b == "'");
        prior_bs     = 1'b0;
      end
    end
  endtask

  task automatic predict_tokens(input in_item_t it);
    logic [7:0] b;
    logic [7:0] q;
    logic       closes;
    pos_t       p;
    b     = it.text_byte;
    p     = position;
    run_n = 0;
    if (it.end_of_text) begin
      close_token(p);
      add_token(KindEnd, KwNone, 1'b0, p, 0);
      reset_scan();
    end else begin
      case (mode)
        ModeWord, ModeInclude: begin
          if (alnum(b) || word_tail(b)) begin
            if (mode == ModeWord) narrow_cands(p - origin, b);
          end else begin
            close_token(p);
            open_token(b, p);
          end
        end
        ModeString: begin
          q        = quote_single ? 8'h27 : 8'h22;
          closes   = (b == q) && !prior_bs;
          prior_bs = (b == 8'h5c);
          if (closes) close_token(p + 1);
        end
        ModeColon, ModeMinus: begin
          // two-character symbols :: and ->
          if ((mode == ModeColon && b == ":") || (mode == ModeMinus && b == ">")) begin
            add_token(KindSymbol, KwNone, 1'b0, origin, 2);
            mode = ModeIdle;
          end else begin
            close_token(p);
            open_token(b, p);
          end
        end
        default: open_token(b, p);
      endcase
      position = p + 1;
    end
    for (int i = 0; i < run_n; i++) begin
      if (i == run_n - 1) run_tok[i].last_of_run = 1'b1;
      token_q.push_back(run_tok[i]);
    end
  endtask

  task automatic check_token(input out_item_t got);
    out_item_t want;
    if (token_q.size() == 0) begin
      fails++;
      if (fails <= ReportMax)
        $display("%0t unexpected token: kind %0d kw %0d q %0b start %0d len %0d last %0b",
                 $realtime, got.token_kind, got.keyword_code, got.is_quoted,
                 got.token_start, got.token_length, got.last_of_run);
    end else begin
      want = token_q.pop_front();
      if (got.token_kind !== want.token_kind || got.keyword_code !== want.keyword_code ||
          got.is_quoted !== want.is_quoted || got.token_start !== want.token_start ||
          got.token_length !== want.token_length || got.last_of_run !== want.last_of_run) begin
        fails++;
        if (fails <= ReportMax)
          $display("%0t token mismatch: exp kind %0d kw %0d q %0b start %0d len %0d last %0b",
                   $realtime, want.token_kind, want.keyword_code, want.is_quoted,
                   want.token_start, want.token_length, want.last_of_run,
                   " / got kind %0d kw %0d q %0b start %0d len %0d last %0b",
                   got.token_kind, got.keyword_code, got.is_quoted,
                   got.token_start, got.token_length, got.last_of_run);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_scan();
      token_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_token(out_item_i);
      if (in_valid_i && in_ready_i) predict_tokens(in_item_i);
      fail_count_o <= fails;
      pending_o    <= token_q.size();
    end
  end

endmodule

[verif/tb_top.sv]
// top of the tokenizer testbench: clock, reset, byte stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
  import stt_pkg::*;

  // random byte items after the directed part
  localparam int RandomItems = 1275;
  // cycles with no item accepted on either channel before giving up
  localparam int QuietLimit  = 2000;

  // character sets for building text
  localparam string Alnum    = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
  localparam string WordHead = "_acefinorstuxyzCFIQ09";
  localparam string WordTail = "_@&[]!|.#?abcfinostu07";
  localparam string SymChars = "{}();.,<>+*/=%&[]!|#?";
  localparam string StrBody  = "ab\\\"' x\\.";
  localparam string OddChars = "$`~^\\";

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  int fail_count;
  int pending;

  // idling on both sides while set
  logic idling;
  int   stall_left = 0;

  in_item_t text_q[$];

  source_text_tokenizer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  tokenizer_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_i   (out_item_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver side: random stall bursts while idling is on
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left  = stall_left - 1;
    end else if (idling && $urandom_range(0, 4) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  = $urandom_range(0, 2);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // watchdog: ends the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [7:0] pick(input string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  function automatic string kw_word(input int k);
    case (k)
      0: return "class";
      1: return "fn";
      2: return "function";
      3: return "constructor";
      4: return "enum";
      default: return "interface";
    endcase
  endfunction

  task automatic add_byte(input logic [7:0] b);
    in_item_t it;
    it.text_byte   = b;
    it.end_of_text = 1'b0;
    text_q.push_back(it);
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // end-of-text item, the byte field carries junk
  task automatic add_eot(input logic [7:0] junk);
    in_item_t it;
    it.text_byte   = junk;
    it.end_of_text = 1'b1;
    text_q.push_back(it);
  endtask

  task automatic add_blank();
    case ($urandom_range(0, 3))
      0, 1: add_byte(8'h20);
      default: add_byte(8'($urandom_range(9, 13)));
    endcase
  endtask

  // one token-shaped piece of text, mostly well formed, some noise
  task automatic add_piece();
    string       kw;
    logic [7:0]  q;
    int          n;
    case ($urandom_range(0, 16))
      0, 1: add_str(kw_word($urandom_range(0, 5)));
      2: begin
        // near misses: prefix, extended, prefixed
        kw = kw_word($urandom_range(0, 5));
        case ($urandom_range(0, 2))
          0: add_str(kw.substr(0, kw.len() - 2));
          1: begin
            add_str(kw);
            add_byte(pick(WordTail));
          end
          default: begin
            add_byte(pick(Alnum));
            add_str(kw);
          end
        endcase
      end
      3, 4: begin
        add_byte(pick(WordHead));
        n = $urandom_range(0, 6);
        repeat (n) add_byte(pick(WordTail));
      end
      5: begin
        add_byte("@");
        n = $urandom_range(0, 5);
        repeat (n) add_byte(pick(WordTail));
      end
      6: add_byte(pick(SymChars));
      7: add_str("::");
      8: add_str("->");
      9: add_byte($urandom_range(0, 1) ? 8'h3a : 8'h2d);
      10, 11: begin
        q = $urandom_range(0, 1) ? 8'h27 : 8'h22;
        add_byte(q);
        n = $urandom_range(0, 6);
        repeat (n) add_byte(pick(StrBody));
        // sometimes left open, then at times cut by end of text
        if ($urandom_range(0, 5) != 0) add_byte(q);
        else if ($urandom_range(0, 1) == 0) add_eot(8'($urandom));
      end
      12: add_blank();
      13: begin
        case ($urandom_range(0, 3))
          0, 1: add_byte(8'($urandom_range(128, 255)));
          2: add_byte(pick(OddChars));
          default: add_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 8))
                                                 : 8'($urandom_range(14, 31)));
        endcase
      end
      14: add_byte(8'($urandom_range(0, 255)));
      default: begin
        if ($urandom_range(0, 2) == 0) add_eot(8'($urandom));
        else add_blank();
      end
    endcase
    if ($urandom_range(0, 1) == 0) add_blank();
  endtask

  // drive one byte item and hold it until accepted
  task automatic send(input in_item_t it);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // hold the sender off until every predicted token has come out
  task automatic drain_tokens();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int sent;
    sent        = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    idling      = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: include, both pairs, escaped quote in a string, keyword,
    // high bytes ending a word, lone minus and colon at end, open string at end
    add_str("@inc::->\"a\\\"\"");
    add_byte(8'hff);
    add_str("fn");
    add_byte(8'h80);
    add_byte(8'h00);
    add_str("-");
    add_eot(8'hff);
    add_str("'x");
    add_eot(8'h00);
    add_str(":");
    add_eot(8'h5a);
    while (text_q.size() != 0) send(text_q.pop_front());
    drain_tokens();

    while (sent < RandomItems) begin
      if (text_q.size() == 0) add_piece();
      // stalls off now and then and over the whole tail
      idling = (sent < RandomItems - 250) && ((sent / 150) % 4 != 3);
      if (sent == RandomItems / 2) drain_tokens();
      send(text_q.pop_front());
      sent++;
    end
    // close whatever is still open
    text_q.delete();
    add_eot(8'($urandom));
    send(text_q.pop_front());
    drain_tokens();
    repeat (20) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
